// File: rtl/string_to_integer_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// String to integer parser assertion macros
// Shared property forms for the parser checks, clocked on clk and gated by
// the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define STIP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/stip_pkg.sv
// ----------------------------------------------------------------------------
// String to integer parser package
// Character codes, base codes, value limits, the result word type and the
// character classification functions shared by the parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package stip_pkg;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;

	// digit value of a character that is no digit at all
	localparam logic [6:0] DIGIT_NONE = 7'd99;
	localparam logic [6:0] DIGIT_HEX_LIMIT = 7'd16;

	// base codes
	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_MIN  = 6'd2;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;
	localparam logic [5:0] BASE_MAX  = 6'd36;
	localparam logic [5:0] BASE_BAD  = 6'd1;

	// saturation limits
	localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

	// result word
	typedef struct packed {
		logic signed [63:0] value;
		logic [15:0]        end_offset;
		logic               digits_found;
		logic               overflowed;
	} stip_res_t;

	// control from the handshake side to the parser
	typedef struct packed {
		logic step;   // process the character held in the input stage
		logic start;  // that character opens a new string
		logic drain;  // the result word leaves this cycle
	} stip_ctl_t;

	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 7'(c - CH_ZERO);
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = 7'(c - CH_LO_A) + 7'd10;
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = 7'(c - CH_UP_A) + 7'd10;
		end
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

// File: rtl/stip_parser.sv
// ----------------------------------------------------------------------------
// String to integer parser core
// Parse state machine with the magnitude accumulator and the result word
// register; takes one character per step.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_parser #(
	parameter longint unsigned MAX_OFFSET = 65535
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire stip_pkg::stip_ctl_t ctl,
	input  wire logic [7:0]         ch,
	input  wire logic [5:0]         base,
	output logic                    res_valid,
	output stip_pkg::stip_res_t     res
);

	localparam int OFF_W     = $clog2(MAX_OFFSET + 1);
	localparam int OFF_EXT_W = (OFF_W > 16) ? OFF_W : 16;
	localparam logic [OFF_W-1:0] OFF_LIMIT = MAX_OFFSET[OFF_W-1:0];

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_HEXPFX,
		PH_DIGITS
	} phase_t;

	phase_t           phase_q, ph_n;
	logic             neg_q, neg_n;
	logic [62:0]      acc_q, acc_n;
	logic             ovf_q, ovf_n;
	logic             have_q, have_n;
	logic [OFF_W-1:0] off_q, off_n;
	logic [5:0]       abase_q, abase_n;

	logic             emit;
	logic             emit_digits;
	logic [OFF_W-1:0] emit_off;
	logic             adv;
	logic             do_start;
	logic             do_take;
	logic [6:0]       dig;
	logic [69:0]      prod;
	logic [63:0]      mag;
	logic [63:0]      val_n;
	logic [OFF_EXT_W-1:0] off_ext;

	assign dig = stip_pkg::digit_of(ch);

	// next state for one character
	always_comb begin
		ph_n        = phase_q;
		neg_n       = neg_q;
		acc_n       = acc_q;
		ovf_n       = ovf_q;
		have_n      = have_q;
		off_n       = off_q;
		abase_n     = abase_q;
		emit        = 1'b0;
		emit_digits = 1'b0;
		emit_off    = off_q;
		adv         = 1'b0;
		do_start    = 1'b0;
		do_take     = 1'b0;
		prod        = '0;

		// a start character clears the parse and latches the base; a bad base code ends the parse with an empty result
		if (ctl.start) begin
			neg_n  = 1'b0;
			acc_n  = '0;
			ovf_n  = 1'b0;
			have_n = 1'b0;
			off_n  = '0;
			if (base == stip_pkg::BASE_BAD || base > stip_pkg::BASE_MAX) begin
				abase_n = stip_pkg::BASE_DEC;
				ph_n    = PH_IDLE;
				emit    = 1'b1;
			end else begin
				abase_n = base;
				ph_n    = PH_SPACE;
			end
		end

		if (!emit) begin
			case (ph_n)
				PH_IDLE: begin
				end
				PH_SPACE: begin
					if (stip_pkg::is_space(ch)) begin
						adv = 1'b1;
					end else if (ch == stip_pkg::CH_MINUS || ch == stip_pkg::CH_PLUS) begin
						neg_n = (ch == stip_pkg::CH_MINUS);
						ph_n  = PH_SIGNED;
						adv   = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
				PH_SIGNED: begin
					do_start = 1'b1;
				end
				PH_ZERO: begin
					if (ch == stip_pkg::CH_LO_X || ch == stip_pkg::CH_UP_X) begin
						abase_n = stip_pkg::BASE_HEX;
						ph_n    = PH_HEXPFX;
						adv     = 1'b1;
					end else begin
						have_n = 1'b1;
						if (abase_n == stip_pkg::BASE_AUTO) begin
							abase_n = stip_pkg::BASE_OCT;
						end
						ph_n    = PH_DIGITS;
						do_take = 1'b1;
					end
				end
				PH_HEXPFX: begin
					if (dig < stip_pkg::DIGIT_HEX_LIMIT) begin
						ph_n    = PH_DIGITS;
						do_take = 1'b1;
					end else begin
						// bare prefix: the lone zero is the number
						have_n      = 1'b1;
						acc_n       = '0;
						emit        = 1'b1;
						emit_digits = 1'b1;
						emit_off    = (off_n != '0) ? off_n - 1'b1 : '0;
					end
				end
				PH_DIGITS: begin
					do_take = 1'b1;
				end
				default: begin
					ph_n = PH_IDLE;
				end
			endcase
		end

		// first character of the number body
		if (do_start) begin
			if (ch == stip_pkg::CH_ZERO &&
			    (abase_n == stip_pkg::BASE_AUTO || abase_n == stip_pkg::BASE_HEX)) begin
				ph_n = PH_ZERO;
				adv  = 1'b1;
			end else begin
				if (abase_n == stip_pkg::BASE_AUTO) begin
					abase_n = stip_pkg::BASE_DEC;
				end
				ph_n    = PH_DIGITS;
				do_take = 1'b1;
			end
		end

		// digit accumulate with saturation test acc*base+d > max
		if (do_take) begin
			if (abase_n < stip_pkg::BASE_MIN || dig >= {1'b0, abase_n}) begin
				emit        = 1'b1;
				emit_digits = have_n;
				emit_off    = off_n;
			end else begin
				have_n = 1'b1;
				prod   = 70'(acc_n) * 70'(abase_n) + 70'(dig);
				if (!ovf_n && (prod[69:63] != '0)) begin
					ovf_n = 1'b1;
				end
				if (!ovf_n) begin
					acc_n = prod[62:0];
				end
				adv = 1'b1;
			end
		end

		// saturating character counter
		if (adv && off_n < OFF_LIMIT) begin
			off_n = off_n + 1'b1;
		end

		if (emit) begin
			ph_n = PH_IDLE;
		end
	end

	// result value from the final state
	assign mag     = {1'b0, acc_n};
	assign off_ext = OFF_EXT_W'(emit_off);
	always_comb begin
		val_n = '0;
		if (emit_digits) begin
			if (ovf_n) begin
				val_n = neg_n ? stip_pkg::VAL_MIN : stip_pkg::VAL_MAX;
			end else begin
				val_n = neg_n ? (64'd0 - mag) : mag;
			end
		end
	end

	// parse state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			have_q    <= 1'b0;
			off_q     <= '0;
			abase_q   <= stip_pkg::BASE_DEC;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			if (ctl.step) begin
				phase_q <= ph_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				have_q  <= have_n;
				off_q   <= off_n;
				abase_q <= abase_n;
			end
			if (ctl.step && emit) begin
				res_valid        <= 1'b1;
				res.value        <= val_n;
				res.end_offset   <= emit_digits ? off_ext[15:0] : 16'd0;
				res.digits_found <= emit_digits;
				res.overflowed   <= emit_digits && ovf_n;
			end else if (ctl.drain) begin
				res_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/string_to_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// String to integer parser unit
// Parses a character stream as signed 64-bit integers, strtol style. One
// character is taken per clock cycle while no result word is stalled:
// each character is registered, then goes through one 63x6-bit multiply-add
// and overflow compare into the parse state, and that accumulator loop sets the rate.
// The character that ends the parse is registered, and the result word is then
// registered in an output register, where it waits. While that word is stalled, one more
// character is taken into the input register, and then the input stalls
// until the word leaves. Configure the base only while the unit is idle;
// it is sampled at each start character.
// ----------------------------------------------------------------------------
`default_nettype none

`include "string_to_integer_parser_unit_macros.svh"

module string_to_integer_parser_unit #(
	parameter longint unsigned MAX_OFFSET = 65535
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [5:0]        base_setting,
	// character input
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        ch,
	input  wire logic              start_req,
	// result output
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [63:0]     value,
	output logic [15:0]            end_offset,
	output logic                   digits_found,
	output logic                   overflowed
);

	logic                valid_s1;
	logic [7:0]          ch_s1;
	logic                start_s1;
	logic [5:0]          base_q;
	logic                advance;
	stip_pkg::stip_ctl_t ctl;
	stip_pkg::stip_res_t res;
	logic                res_valid;

	// base register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= stip_pkg::BASE_DEC;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= base_setting;
		end
	end

	// input stage moves on unless a waiting result blocks the output
	assign advance  = valid_s1 && (!res_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
		end
	end

	// parse core
	assign ctl.step  = advance;
	assign ctl.start = start_s1;
	assign ctl.drain = res_valid && !out_stall;

	stip_parser #(
		.MAX_OFFSET(MAX_OFFSET)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ch       (ch_s1),
		.base     (base_q),
		.res_valid(res_valid),
		.res      (res)
	);

	// output word
	assign out_valid    = res_valid;
	assign value        = res.value;
	assign end_offset   = res.end_offset;
	assign digits_found = res.digits_found;
	assign overflowed   = res.overflowed;

	// checks
	`STIP_ASSERT_SAME(a_no_digit_zero, out_valid && !digits_found, value == 64'sd0 && end_offset == 16'd0 && !overflowed, "result without digits is not all zero")
	`STIP_ASSERT_SAME(a_ovf_saturates, out_valid && overflowed, value == stip_pkg::VAL_MAX || value == stip_pkg::VAL_MIN, "overflowed result is not saturated")
	`STIP_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall && valid_s1, "input stalled without a blocked result")
	`STIP_ASSERT_NEXT(a_drain_clears, out_valid && !out_stall && !valid_s1, !out_valid, "result word repeated after delivery")

endmodule

`default_nettype wire
